>>> rtl/slpq_pkg.sv
// slpq_pkg: types and constants shared by the sorted list priority queue
// used by slpq_ctrl, slpq_datapath and sorted_list_priority_queue
package slpq_pkg;

    localparam int CAPACITY    = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int OUT_W       = 32;
    localparam int IN_W        = 32;
    localparam int OCC_W       = 5;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_POP    = 2'd1,
        MODE_FIND   = 2'd2,
        MODE_NOP    = 2'd3
    } t_mode;

    typedef enum logic {
        S_IDLE,
        S_HOLD
    } t_state;

    typedef struct packed {
        t_mode             mode;
        logic [IN_W-1:0]   value;
    } t_in;

    typedef struct packed {
        logic              ok;
        logic [OUT_W-1:0]  out_value;
        logic [OCC_W-1:0]  occupancy;
    } t_out;

endpackage

>>> rtl/slpq_ctrl.sv
// slpq_ctrl: handshake controller, decides when the datapath executes
// depends on slpq_pkg
module slpq_ctrl (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_out_stall,
    output logic o_in_stall,
    output logic o_out_valid,
    output logic o_exec
);

    slpq_pkg::t_state r_state;
    slpq_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= slpq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_stall  = 1'b0;
        o_out_valid = 1'b0;
        o_exec      = 1'b0;
        case (r_state)
            slpq_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_exec  = 1'b1;
                    n_state = slpq_pkg::S_HOLD;
                end
            end
            slpq_pkg::S_HOLD: begin
                o_out_valid = 1'b1;
                o_in_stall  = i_out_stall;
                if (!i_out_stall) begin
                    if (i_in_valid) begin
                        o_exec = 1'b1;
                    end else begin
                        n_state = slpq_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = slpq_pkg::S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/slpq_datapath.sv
// slpq_datapath: sorted entry cells, count and result register
// depends on slpq_pkg
module slpq_datapath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_exec,
    input  slpq_pkg::t_in  i_in,
    output slpq_pkg::t_out o_out
);

    logic [slpq_pkg::VALUE_WIDTH-1:0] r_entries [slpq_pkg::CAPACITY];
    logic [slpq_pkg::VALUE_WIDTH-1:0] n_entries [slpq_pkg::CAPACITY];
    logic [slpq_pkg::CNT_W-1:0]       r_count;
    logic [slpq_pkg::CNT_W-1:0]       n_count;
    slpq_pkg::t_out                   r_out;
    slpq_pkg::t_out                   n_out;

    logic [slpq_pkg::VALUE_WIDTH-1:0] v;
    logic [slpq_pkg::CAPACITY-1:0]    live;
    logic [slpq_pkg::CAPACITY-1:0]    lt;
    logic [slpq_pkg::CAPACITY-1:0]    eq;
    logic                             full;
    logic                             empty;

    always_comb begin
        v     = i_in.value[slpq_pkg::VALUE_WIDTH-1:0];
        full  = (r_count == slpq_pkg::CNT_W'(slpq_pkg::CAPACITY));
        empty = (r_count == '0);
        for (int i = 0; i < slpq_pkg::CAPACITY; i++) begin
            live[i] = (slpq_pkg::CNT_W'(i) < r_count);
            lt[i]   = live[i] && (r_entries[i] < v);
            eq[i]   = live[i] && (r_entries[i] == v);
        end

        n_entries       = r_entries;
        n_count         = r_count;
        n_out.ok        = 1'b0;
        n_out.out_value = '0;

        case (i_in.mode)
            slpq_pkg::MODE_INSERT: begin
                if (!full) begin
                    if (!lt[0]) begin
                        n_entries[0] = v;
                    end
                    for (int i = 1; i < slpq_pkg::CAPACITY; i++) begin
                        if (!lt[i]) begin
                            n_entries[i] = lt[i-1] ? v : r_entries[i-1];
                        end
                    end
                    n_count  = r_count + slpq_pkg::CNT_W'(1);
                    n_out.ok = 1'b1;
                end
            end
            slpq_pkg::MODE_POP: begin
                if (!empty) begin
                    n_out.out_value = slpq_pkg::OUT_W'(r_entries[0]);
                    for (int i = 0; i < slpq_pkg::CAPACITY - 1; i++) begin
                        n_entries[i] = r_entries[i+1];
                    end
                    n_count  = r_count - slpq_pkg::CNT_W'(1);
                    n_out.ok = 1'b1;
                end
            end
            slpq_pkg::MODE_FIND: begin
                n_out.ok = |eq;
            end
            default: begin
                n_out.ok = 1'b0;
            end
        endcase

        n_out.occupancy = slpq_pkg::OCC_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_exec) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_exec) begin
            r_entries <= n_entries;
            r_out     <= n_out;
        end
    end

    assign o_out = r_out;

endmodule

>>> rtl/sorted_list_priority_queue.sv
// sorted_list_priority_queue: top level, controller plus datapath
// depends on slpq_pkg, slpq_ctrl, slpq_datapath
//
// Bounded priority queue of up to 16 unsigned 32-bit values kept in ascending order
// in a row of register cells. Each transfer on the input carries one operation (insert,
// pop smallest, find) and produces exactly one result transfer with ok, the popped
// value and the occupancy after the operation. All cells compare against the operand
// in parallel and shift in the same cycle, so one operation executes per clock: the
// result appears in the cycle after the input transfer, and a new item is taken in the
// same cycle as the pending result is taken, giving one item per cycle while the output
// is not stalled. Stored values have no reset; the count resets to empty.
module sorted_list_priority_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  slpq_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output slpq_pkg::t_out o_out
);

    logic cmd_exec;

    slpq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_exec      (cmd_exec)
    );

    slpq_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_exec  (cmd_exec),
        .i_in    (i_in),
        .o_out   (o_out)
    );

    a_exec_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_exec |=> o_out_valid)
        else $error("result not presented after execute");

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.occupancy <= slpq_pkg::OCC_W'(slpq_pkg::CAPACITY)))
        else $error("occupancy beyond capacity");

    a_fail_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.ok) |-> (o_out.out_value == '0))
        else $error("nonzero value on failed operation");

endmodule

>>> tb/sv/sorted_list_priority_queue_tb.sv
// sorted_list_priority_queue_tb: self-checking bench for the sorted list priority queue
// drives insert, pop, find and no-op transfers and checks every result against a local queue
// model; depends on slpq_pkg and sorted_list_priority_queue
module sorted_list_priority_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int PHASE_ITEMS    = 350;
    localparam int MAX_MSG_LINES  = 60;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_in_valid;
    logic           o_in_stall;
    slpq_pkg::t_in  i_in;
    logic           o_out_valid;
    logic           i_out_stall;
    slpq_pkg::t_out o_out;

    sorted_list_priority_queue i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    // queue model state
    logic [slpq_pkg::VALUE_WIDTH-1:0] model_vals [slpq_pkg::CAPACITY];
    int                               model_cnt = 0;
    slpq_pkg::t_out                   pending_results [$];

    int mismatch_cnt  = 0;
    int cycle_cnt     = 0;
    int in_idle_pct   = 0;
    int out_stall_pct = 0;

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    function automatic slpq_pkg::t_out apply_queue_op(slpq_pkg::t_in item);
        slpq_pkg::t_out                   res;
        logic [slpq_pkg::VALUE_WIDTH-1:0] v;
        int                               pos;
        res = '0;
        v   = slpq_pkg::VALUE_WIDTH'(item.value);
        case (item.mode)
            slpq_pkg::MODE_INSERT: begin
                if (model_cnt < slpq_pkg::CAPACITY) begin
                    pos = 0;
                    while (pos < model_cnt && model_vals[pos] < v)
                        pos++;
                    for (int i = model_cnt; i > pos; i--)
                        model_vals[i] = model_vals[i-1];
                    model_vals[pos] = v;
                    model_cnt++;
                    res.ok = 1'b1;
                end
            end
            slpq_pkg::MODE_POP: begin
                if (model_cnt > 0) begin
                    res.out_value = slpq_pkg::OUT_W'(model_vals[0]);
                    for (int i = 1; i < model_cnt; i++)
                        model_vals[i-1] = model_vals[i];
                    model_cnt--;
                    res.ok = 1'b1;
                end
            end
            slpq_pkg::MODE_FIND: begin
                for (int i = 0; i < model_cnt; i++)
                    if (model_vals[i] == v)
                        res.ok = 1'b1;
            end
            default: begin
            end
        endcase
        res.occupancy = slpq_pkg::OCC_W'(model_cnt);
        return res;
    endfunction

    task automatic report_mismatch(string what);
        if (mismatch_cnt < MAX_MSG_LINES)
            $display("mismatch at cycle %0d: %s", cycle_cnt, what);
        mismatch_cnt++;
    endtask

    // result check first, then the model takes the input transfer of the same edge
    always @(posedge i_clk) begin
        slpq_pkg::t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result transfer with nothing pending");
            end else begin
                want = pending_results.pop_front();
                if (o_out.ok !== want.ok)
                    report_mismatch($sformatf("ok got %b want %b", o_out.ok, want.ok));
                if (o_out.out_value !== want.out_value)
                    report_mismatch($sformatf("out_value got %h want %h",
                                              o_out.out_value, want.out_value));
                if (o_out.occupancy !== want.occupancy)
                    report_mismatch($sformatf("occupancy got %0d want %0d",
                                              o_out.occupancy, want.occupancy));
            end
        end
        if (i_rst_n && i_in_valid && !o_in_stall)
            pending_results.push_back(apply_queue_op(i_in));
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("FAIL");
        $finish;
    end

    task automatic send_op(slpq_pkg::t_mode m, logic [slpq_pkg::IN_W-1:0] v);
        slpq_pkg::t_in item;
        item.mode  = m;
        item.value = v;
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= item;
        do
            @(posedge i_clk);
        while (o_in_stall);
    endtask

    function automatic logic [slpq_pkg::IN_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2, 3: return slpq_pkg::IN_W'($urandom_range(15));
            4, 5: begin
                if (model_cnt > 0)
                    return slpq_pkg::IN_W'(model_vals[$urandom_range(model_cnt - 1)]);
                return slpq_pkg::IN_W'($urandom);
            end
            6: return {1'b1, (slpq_pkg::IN_W-1)'($urandom_range(3))};
            default: return slpq_pkg::IN_W'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        send_op(slpq_pkg::MODE_POP, 32'h1234_5678);
        send_op(slpq_pkg::MODE_FIND, '0);
        send_op(slpq_pkg::MODE_NOP, '1);
        send_op(slpq_pkg::MODE_INSERT, '1);
        send_op(slpq_pkg::MODE_INSERT, '0);
        send_op(slpq_pkg::MODE_INSERT, '0);
        send_op(slpq_pkg::MODE_INSERT, 32'h8000_0000);
        send_op(slpq_pkg::MODE_FIND, '0);
        send_op(slpq_pkg::MODE_FIND, '1);
        send_op(slpq_pkg::MODE_FIND, 32'h7fff_ffff);
        for (int i = 12; i > 0; i--)
            send_op(slpq_pkg::MODE_INSERT, slpq_pkg::IN_W'(i));
        send_op(slpq_pkg::MODE_INSERT, 32'd5);
        send_op(slpq_pkg::MODE_FIND, 32'd5);
        send_op(slpq_pkg::MODE_POP, '0);
    endtask

    // bursts that lean toward filling, draining or neither so full and empty are both hit often
    task automatic run_random_ops(int n_items);
        int              lean;
        int              burst_left;
        int              r;
        slpq_pkg::t_mode m;
        burst_left = 0;
        lean       = 0;
        for (int k = 0; k < n_items; k++) begin
            if (burst_left == 0) begin
                lean       = $urandom_range(2);
                burst_left = $urandom_range(8, 30);
            end
            burst_left--;
            r = $urandom_range(99);
            if (r < 5)
                m = slpq_pkg::MODE_NOP;
            else if (r < 20)
                m = slpq_pkg::MODE_FIND;
            else if (lean == 0)
                m = (r < 80) ? slpq_pkg::MODE_INSERT : slpq_pkg::MODE_POP;
            else if (lean == 1)
                m = (r < 40) ? slpq_pkg::MODE_INSERT : slpq_pkg::MODE_POP;
            else
                m = (r < 60) ? slpq_pkg::MODE_INSERT : slpq_pkg::MODE_POP;
            send_op(m, pick_value());
        end
    endtask

    task automatic test_random_slow_sink();
        in_idle_pct   = 24;
        out_stall_pct = 87;
        run_random_ops(PHASE_ITEMS);
    endtask

    task automatic test_random_slow_source();
        in_idle_pct   = 87;
        out_stall_pct = 24;
        run_random_ops(PHASE_ITEMS);
    endtask

    task automatic test_random_full_rate();
        in_idle_pct   = 0;
        out_stall_pct = 0;
        run_random_ops(PHASE_ITEMS);
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in        <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_slow_sink();
        test_random_slow_source();
        test_random_full_rate();

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
